@@ src/hdr_luminance_tone_mapper_core_macros.svh @@
// Assertion helpers shared by the tone mapper RTL.
// Both sample on aclk and stay quiet while aresetn is low.
`ifndef HDR_LUMINANCE_TONE_MAPPER_CORE_MACROS_SVH
`define HDR_LUMINANCE_TONE_MAPPER_CORE_MACROS_SVH

// Same-cycle implication
`define HLTM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HLTM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hltm_pkg.sv @@
`default_nettype none

package hltm_pkg;

    // Curve table resolution
    localparam int CURVE_TABLE_BITS = 10;
    localparam int TBL_N            = 1 << CURVE_TABLE_BITS;
    localparam int EXP_SH           = 20 - CURVE_TABLE_BITS;
    localparam int POW_SH           = 16 - CURVE_TABLE_BITS;

    // Pipelined divider: one quotient bit per stage plus an entry stage
    localparam int DIV_QBITS = 32;
    localparam int DIV_LAT   = DIV_QBITS + 1;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    // Filmic curve constants, Q16.16
    localparam logic [31:0] FILM_X0    = 32'd262;
    localparam logic [31:0] FILM_XCLIP = 32'h1000_0000;
    localparam logic [31:0] FILM_A     = 32'd406323;
    localparam logic [31:0] FILM_B     = 32'd32768;
    localparam logic [31:0] FILM_C     = 32'd111411;
    localparam logic [31:0] FILM_D     = 32'd3932;

    // Configuration register indexes
    localparam logic [1:0] CFG_CURVE_MODE    = 2'd0;
    localparam logic [1:0] CFG_EXPOSURE_GAIN = 2'd1;
    localparam logic [1:0] CFG_INV_WHITE_SQ  = 2'd2;

    typedef enum logic [2:0] {
        CM_LINEAR      = 3'd0,
        CM_COMPRESS    = 3'd1,
        CM_REINHARD    = 3'd2,
        CM_EXPONENTIAL = 3'd3,
        CM_FILMIC      = 3'd4
    } curve_mode_t;

    typedef struct packed {
        logic [31:0] sum_x;
        logic [31:0] sum_y;
        logic [31:0] sum_z;
        logic [31:0] weight_sum;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic        saturated;
    } out_item_t;

    // Divider result: quotient and "does not fit in 32 bits"
    typedef struct packed {
        logic [31:0] quot;
        logic        ovf;
    } div_res_t;

    // Per-pixel data carried alongside the long arithmetic
    typedef struct packed {
        logic [31:0] lin_x;
        logic [31:0] lin_y;
        logic [31:0] lin_z;
        logic        sat;
        logic        zero;
        logic        special;
    } side_t;

    typedef logic [31:0] curve_tab_t [0:TBL_N];

    // exp(-16 i / N): repeated multiply by a Taylor value of the step
    function automatic curve_tab_t build_exp_tab();
        curve_tab_t  tab;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] step;
        logic [63:0] cur;
        x    = 64'd1 << (36 - CURVE_TABLE_BITS);
        term = 64'd1 << 32;
        pos  = term;
        neg  = 64'd0;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * x) >> 32) / 64'(k);
            if ((k % 2) == 1) neg = neg + term;
            else pos = pos + term;
        end
        step = pos - neg;
        cur  = 64'd1 << 32;
        for (int i = 0; i <= TBL_N; i++) begin
            tab[i] = 32'((cur + 64'd32768) >> 16);
            cur    = (cur * step) >> 32;
        end
        return tab;
    endfunction

    // y^2.2 = y^2 * y^(1/5), fifth root by binary search
    function automatic curve_tab_t build_pow_tab();
        curve_tab_t  tab;
        logic [63:0] target;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        logic [63:0] sq;
        for (int i = 0; i <= TBL_N; i++) begin
            target = 64'(i) << (60 - CURVE_TABLE_BITS);
            lo = 64'd0;
            hi = 64'd4096;
            for (int n = 0; n < 16; n++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 64'd1) >> 1;
                    p   = mid * mid;
                    p   = p * p * mid;
                    if (p <= target) lo = mid;
                    else hi = mid - 64'd1;
                end
            end
            sq     = (64'(i) * 64'(i)) << (32 - 2 * CURVE_TABLE_BITS);
            tab[i] = 32'((sq * lo) >> 28);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

@@ src/hltm_div.sv @@
`default_nettype none

// Pipelined restoring divider, 64 / 48 bits, 32-bit quotient plus an overflow flag.
// One quotient bit per stage; all stages advance on en.
module hltm_div (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [63:0]       dividend,
    input  wire logic [47:0]       divisor,
    output hltm_pkg::div_res_t     res
);

    logic [47:0] rem_reg  [0:hltm_pkg::DIV_LAT-1];
    logic [31:0] lo_reg   [0:hltm_pkg::DIV_LAT-1];
    logic [31:0] quot_reg [0:hltm_pkg::DIV_LAT-1];
    logic [47:0] dvs_reg  [0:hltm_pkg::DIV_LAT-1];
    logic        ovf_reg  [0:hltm_pkg::DIV_LAT-1];

    logic [47:0] rem_next  [1:hltm_pkg::DIV_LAT-1];
    logic [31:0] quot_next [1:hltm_pkg::DIV_LAT-1];

    // One trial subtraction per stage
    always_comb begin
        logic [48:0] trial;
        logic        ge;
        for (int j = 1; j < hltm_pkg::DIV_LAT; j++) begin
            trial        = {rem_reg[j-1], lo_reg[j-1][31]};
            ge           = trial >= {1'b0, dvs_reg[j-1]};
            rem_next[j]  = ge ? 48'(trial - {1'b0, dvs_reg[j-1]}) : trial[47:0];
            quot_next[j] = {quot_reg[j-1][30:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Entry: quotient overflows when the high half reaches the divisor
            rem_reg[0]  <= {16'd0, dividend[63:32]};
            lo_reg[0]   <= dividend[31:0];
            quot_reg[0] <= '0;
            dvs_reg[0]  <= divisor;
            ovf_reg[0]  <= {16'd0, dividend[63:32]} >= divisor;
            for (int j = 1; j < hltm_pkg::DIV_LAT; j++) begin
                rem_reg[j]  <= rem_next[j];
                lo_reg[j]   <= {lo_reg[j-1][30:0], 1'b0};
                quot_reg[j] <= quot_next[j];
                dvs_reg[j]  <= dvs_reg[j-1];
                ovf_reg[j]  <= ovf_reg[j-1];
            end
        end
    end

    assign res.quot = quot_reg[hltm_pkg::DIV_LAT-1];
    assign res.ovf  = ovf_reg[hltm_pkg::DIV_LAT-1];

endmodule

`default_nettype wire

@@ src/hdr_luminance_tone_mapper_core.sv @@
`default_nettype none
`include "hdr_luminance_tone_mapper_core_macros.svh"

// HDR luminance tone mapper, one pixel per word, all values unsigned Q16.16.
// s_*: pixel sums and weight in; m_*: tone-mapped XYZ and a saturation flag out.
// cfg_*: register writes (0 curve_mode, 1 exposure_gain, 2 inv_white_squared);
// always ready; user must write only while no pixel is in flight (unenforced).
// Throughput: one word per clock unless m_ready stalls the output. From s_
// acceptance to m_valid, words pass three chained 33-stage dividers (normalize,
// filmic curve, curve ratio) plus multiply, table and clip stages.
// A stall on m_ready freezes the whole pipeline; the input register still
// takes one word while empty, so s_ready drops only when it is also full.
// Reset clears all valid bits and loads the register reset values
// (linear curve, gain 1.0, white term 0). Table ROMs need no fill.
module hdr_luminance_tone_mapper_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire hltm_pkg::in_item_t   s_data,
    output      logic                 m_valid,
    input  wire logic                 m_ready,
    output      hltm_pkg::out_item_t  m_data,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int LAST = hltm_pkg::DIV_LAT - 1;
    localparam int TB   = hltm_pkg::CURVE_TABLE_BITS;
    localparam int ESH  = hltm_pkg::EXP_SH;
    localparam int PSH  = hltm_pkg::POW_SH;

    localparam hltm_pkg::curve_tab_t EXP_ROM = hltm_pkg::build_exp_tab();
    localparam hltm_pkg::curve_tab_t POW_ROM = hltm_pkg::build_pow_tab();

    logic en;

    hltm_pkg::curve_mode_t mode_reg;
    logic [31:0]           gain_reg;
    logic [31:0]           iws_reg;

    hltm_pkg::in_item_t in_reg;
    logic               v0_reg;

    logic [63:0] px_reg, py_reg, pz_reg;
    logic [31:0] w1_reg;
    logic        z1_reg, v1_reg;

    hltm_pkg::div_res_t dx_res, dy_res, dz_res, yb_res, rc_res;
    logic               za_reg [0:LAST];
    logic               va_reg [0:LAST];

    hltm_pkg::side_t s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg, s8_reg;
    logic            v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;

    logic [28:0] xp_reg;
    logic [31:0] a_reg;
    logic [45:0] nr_reg;
    logic [46:0] dr_reg;

    hltm_pkg::side_t sb_reg [0:LAST];
    logic            vb_reg [0:LAST];
    hltm_pkg::side_t sc_reg [0:LAST];
    logic            vc_reg [0:LAST];

    logic [31:0]    p0_reg, p1_reg, e0_reg, e1_reg;
    logic [PSH-1:0] pfr_reg;
    logic [ESH-1:0] efr_reg;
    logic           pclamp_reg, efar_reg;
    logic [63:0]    rp_reg;

    logic [31:0] pow_reg, e_reg;
    logic [47:0] num_reg;

    logic [31:0] ratio_reg;
    logic [63:0] ox_reg, oy_reg, oz_reg;

    hltm_pkg::out_item_t m_data_reg;
    logic                m_valid_reg;

    // Handshake: whole pipeline moves unless a result word is held
    assign en        = m_ready || !m_valid_reg;
    assign s_ready   = en || !v0_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= hltm_pkg::CM_LINEAR;
            gain_reg <= hltm_pkg::Q_ONE;
            iws_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hltm_pkg::CFG_CURVE_MODE:    mode_reg <= hltm_pkg::curve_mode_t'(cfg_data[2:0]);
                hltm_pkg::CFG_EXPOSURE_GAIN: gain_reg <= cfg_data;
                hltm_pkg::CFG_INV_WHITE_SQ:  iws_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k <= LAST; k++) begin
                va_reg[k] <= 1'b0;
                vb_reg[k] <= 1'b0;
                vc_reg[k] <= 1'b0;
            end
        end else begin
            if (s_ready) v0_reg <= s_valid;
            if (en) begin
                v1_reg    <= v0_reg;
                va_reg[0] <= v1_reg;
                v2_reg    <= va_reg[LAST];
                v3_reg    <= v2_reg;
                v4_reg    <= v3_reg;
                vb_reg[0] <= v4_reg;
                v5_reg    <= vb_reg[LAST];
                v6_reg    <= v5_reg;
                vc_reg[0] <= v6_reg;
                v7_reg    <= vc_reg[LAST];
                v8_reg    <= v7_reg;
                m_valid_reg <= v8_reg;
                for (int k = 1; k <= LAST; k++) begin
                    va_reg[k] <= va_reg[k-1];
                    vb_reg[k] <= vb_reg[k-1];
                    vc_reg[k] <= vc_reg[k-1];
                end
            end
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (s_ready) in_reg <= s_data;
    end

    // Stage 1: sums times exposure gain
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= 64'(in_reg.sum_x) * 64'(gain_reg);
            py_reg <= 64'(in_reg.sum_y) * 64'(gain_reg);
            pz_reg <= 64'(in_reg.sum_z) * 64'(gain_reg);
            w1_reg <= in_reg.weight_sum;
            z1_reg <= in_reg.weight_sum == '0;
        end
    end

    // Normalize by the weight sum
    hltm_div u_div_x (
        .aclk(aclk), .en(en), .dividend(px_reg), .divisor({16'd0, w1_reg}), .res(dx_res)
    );
    hltm_div u_div_y (
        .aclk(aclk), .en(en), .dividend(py_reg), .divisor({16'd0, w1_reg}), .res(dy_res)
    );
    hltm_div u_div_z (
        .aclk(aclk), .en(en), .dividend(pz_reg), .divisor({16'd0, w1_reg}), .res(dz_res)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            za_reg[0] <= z1_reg;
            for (int k = 1; k <= LAST; k++) za_reg[k] <= za_reg[k-1];
        end
    end

    // Stage 2: clip linear values
    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg.lin_x   <= dx_res.ovf ? hltm_pkg::MAX32 : dx_res.quot;
            s2_reg.lin_y   <= dy_res.ovf ? hltm_pkg::MAX32 : dy_res.quot;
            s2_reg.lin_z   <= dz_res.ovf ? hltm_pkg::MAX32 : dz_res.quot;
            s2_reg.sat     <= dx_res.ovf || dy_res.ovf || dz_res.ovf;
            s2_reg.zero    <= za_reg[LAST];
            s2_reg.special <= 1'b0;
        end
    end

    // Stage 3: filmic offset, clip and first product
    logic [31:0] film_xs;
    logic [28:0] film_xp;
    logic [47:0] film_a;

    always_comb begin
        film_xs = (s2_reg.lin_y > hltm_pkg::FILM_X0) ? s2_reg.lin_y - hltm_pkg::FILM_X0 : '0;
        film_xp = (film_xs > hltm_pkg::FILM_XCLIP) ? hltm_pkg::FILM_XCLIP[28:0] : film_xs[28:0];
        film_a  = 48'(hltm_pkg::FILM_A) * 48'(film_xp);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xp_reg <= film_xp;
            a_reg  <= film_a[47:16];
            s3_reg <= s2_reg;
        end
    end

    // Stage 4: filmic numerator and denominator
    logic [61:0] film_nr;
    logic [61:0] film_dr;

    always_comb begin
        film_nr = 62'(33'(a_reg) + 33'(hltm_pkg::FILM_B)) * 62'(xp_reg);
        film_dr = 62'(33'(a_reg) + 33'(hltm_pkg::FILM_C)) * 62'(xp_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nr_reg <= film_nr[61:16];
            dr_reg <= 47'(film_dr[61:16]) + 47'(hltm_pkg::FILM_D);
            s4_reg <= s3_reg;
        end
    end

    // Filmic y = nr / dr
    hltm_div u_div_film (
        .aclk(aclk), .en(en), .dividend({2'b00, nr_reg, 16'd0}), .divisor({1'b0, dr_reg}),
        .res(yb_res)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= s4_reg;
            for (int k = 1; k <= LAST; k++) sb_reg[k] <= sb_reg[k-1];
        end
    end

    // Stage 5: table reads and the Reinhard product
    logic          pclamp;
    logic [TB:0]   pidx;
    logic          efar;
    logic [TB:0]   eidx;
    logic [31:0]   l5;

    always_comb begin
        l5     = sb_reg[LAST].lin_y;
        pclamp = yb_res.ovf || (yb_res.quot[31:16] != '0);
        pidx   = pclamp ? '0 : {1'b0, yb_res.quot[15:PSH]};
        efar   = l5[31:20] != '0;
        eidx   = {1'b0, l5[19:ESH]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg     <= POW_ROM[pidx];
            p1_reg     <= POW_ROM[pidx + 1'b1];
            pfr_reg    <= yb_res.quot[PSH-1:0];
            pclamp_reg <= pclamp;
            e0_reg     <= EXP_ROM[eidx];
            e1_reg     <= EXP_ROM[eidx + 1'b1];
            efr_reg    <= l5[ESH-1:0];
            efar_reg   <= efar;
            rp_reg     <= 64'(l5) * 64'(iws_reg);
            s5_reg     <= sb_reg[LAST];
        end
    end

    // Stage 6: interpolation, Reinhard numerator, mode special cases
    logic [31:0]     pdiff, ediff;
    logic [31+PSH:0] pmul;
    logic [31+ESH:0] emul;
    logic [48:0]     num_full;
    logic            special;

    always_comb begin
        pdiff    = p1_reg - p0_reg;
        ediff    = e0_reg - e1_reg;
        pmul     = (32+PSH)'(pdiff) * (32+PSH)'(pfr_reg);
        emul     = (32+ESH)'(ediff) * (32+ESH)'(efr_reg);
        num_full = 49'(rp_reg[63:16]) + 49'(hltm_pkg::Q_ONE);
        unique case (mode_reg) inside
            hltm_pkg::CM_COMPRESS,
            hltm_pkg::CM_REINHARD,
            hltm_pkg::CM_FILMIC:      special = 1'b0;
            hltm_pkg::CM_EXPONENTIAL: special = s5_reg.lin_y == '0;
            default:                  special = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pow_reg <= pclamp_reg ? POW_ROM[hltm_pkg::TBL_N] : p0_reg + pmul[31+PSH:PSH];
            e_reg   <= efar_reg ? '0 : e0_reg - emul[31+ESH:ESH];
            num_reg <= num_full[48] ? '1 : num_full[47:0];
            s6_reg  <= '{lin_x: s5_reg.lin_x, lin_y: s5_reg.lin_y, lin_z: s5_reg.lin_z,
                         sat: s5_reg.sat, zero: s5_reg.zero, special: special};
        end
    end

    // Curve ratio operands by mode
    logic [63:0] r_dvd;
    logic [47:0] r_dvs;
    logic [31:0] l6;

    always_comb begin
        l6 = s6_reg.lin_y;
        unique case (mode_reg)
            hltm_pkg::CM_COMPRESS: begin
                r_dvd = 64'h1_0000_0000;
                r_dvs = 48'(l6) + 48'(hltm_pkg::Q_ONE);
            end
            hltm_pkg::CM_REINHARD: begin
                r_dvd = {num_reg, 16'd0};
                r_dvs = 48'(l6) + 48'(hltm_pkg::Q_ONE);
            end
            hltm_pkg::CM_EXPONENTIAL: begin
                r_dvd = {16'd0, hltm_pkg::Q_ONE - e_reg, 16'd0};
                r_dvs = 48'(l6);
            end
            hltm_pkg::CM_FILMIC: begin
                r_dvd = {16'd0, pow_reg, 16'd0};
                r_dvs = 48'((l6 > hltm_pkg::FILM_X0) ? l6 : hltm_pkg::FILM_X0);
            end
            default: begin
                r_dvd = '0;
                r_dvs = 48'd1;
            end
        endcase
    end

    hltm_div u_div_ratio (
        .aclk(aclk), .en(en), .dividend(r_dvd), .divisor(r_dvs), .res(rc_res)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg[0] <= s6_reg;
            for (int k = 1; k <= LAST; k++) sc_reg[k] <= sc_reg[k-1];
        end
    end

    // Stage 7: final ratio
    always_ff @(posedge aclk) begin
        if (en) begin
            if (sc_reg[LAST].special) ratio_reg <= hltm_pkg::Q_ONE;
            else ratio_reg <= rc_res.ovf ? hltm_pkg::MAX32 : rc_res.quot;
            s7_reg <= sc_reg[LAST];
        end
    end

    // Stage 8: scale components
    always_ff @(posedge aclk) begin
        if (en) begin
            ox_reg <= 64'(s7_reg.lin_x) * 64'(ratio_reg);
            oy_reg <= 64'(s7_reg.lin_y) * 64'(ratio_reg);
            oz_reg <= 64'(s7_reg.lin_z) * 64'(ratio_reg);
            s8_reg <= s7_reg;
        end
    end

    // Output register: clip, empty pixel forces zero
    logic cx, cy, cz;

    always_comb begin
        cx = ox_reg[63:48] != '0;
        cy = oy_reg[63:48] != '0;
        cz = oz_reg[63:48] != '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (s8_reg.zero) begin
                m_data_reg <= '0;
            end else begin
                m_data_reg.out_x     <= cx ? hltm_pkg::MAX32 : ox_reg[47:16];
                m_data_reg.out_y     <= cy ? hltm_pkg::MAX32 : oy_reg[47:16];
                m_data_reg.out_z     <= cz ? hltm_pkg::MAX32 : oz_reg[47:16];
                m_data_reg.saturated <= s8_reg.sat || cx || cy || cz;
            end
        end
    end

    // Checks
    logic sp_hit;

    assign sp_hit = en && vc_reg[LAST] && sc_reg[LAST].special;

    `HLTM_ASSERT_IMP(a_ready_low, !s_ready, v0_reg && m_valid_reg && !m_ready, "s_ready dropped")
    `HLTM_ASSERT_NXT(a_empty, en && v8_reg && s8_reg.zero, m_data_reg == '0, "empty pixel out")
    `HLTM_ASSERT_NXT(a_special, sp_hit, ratio_reg == hltm_pkg::Q_ONE, "special ratio not 1.0")

endmodule

`default_nettype wire
